### design/crc16_frame_generate_check_defines.svh
// Assertion helpers for the checking code of the CRC framer
`ifndef CRC16_FRAME_GENERATE_CHECK_DEFINES_SVH
`define CRC16_FRAME_GENERATE_CHECK_DEFINES_SVH

// same-cycle implication
`define CRCFG_ASSERT_NOW(label, clock, rstn, ante, cons) \
  label: assert property (@(posedge clock) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("crcfg assertion failed");

// next-cycle implication
`define CRCFG_ASSERT_NEXT(label, clock, rstn, ante, cons) \
  label: assert property (@(posedge clock) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("crcfg assertion failed");

`endif

### design/crcfg_pkg.sv
`timescale 1ns / 1ps
package crcfg_pkg;

  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] POLY_RESET = 16'h8408;

  // register indexes on the configuration port
  localparam logic REG_POLY = 1'b0;
  localparam logic REG_MODE = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } crcfg_in_t;

  typedef struct packed {
    logic [15:0] crc_value;
    logic        crc_match;
    logic        frame_too_short;
  } crcfg_out_t;

  typedef struct packed {
    logic [15:0] polynomial;
    logic        check_mode;
  } crcfg_cfg_t;

endpackage

### design/crcfg_regs.sv
`timescale 1ns / 1ps
module crcfg_regs (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output crcfg_pkg::crcfg_cfg_t cfg
);
  import crcfg_pkg::*;

  logic [15:0] poly_r;
  logic        mode_r;
  logic        wr_en;
  logic        reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_r <= POLY_RESET;
      mode_r <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_POLY: poly_r <= pwdata[15:0];
        REG_MODE: mode_r <= pwdata[0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_POLY: prdata = {16'd0, poly_r};
      REG_MODE: prdata = {31'd0, mode_r};
      default:  prdata = 32'd0;
    endcase
  end

  assign cfg.polynomial = poly_r;
  assign cfg.check_mode = mode_r;

endmodule

### design/crcfg_crc_byte.sv
`timescale 1ns / 1ps
module crcfg_crc_byte (
  input  logic [15:0] crc_in,
  input  logic [7:0]  data,
  input  logic [15:0] polynomial,
  output logic [15:0] crc_out
);
  import crcfg_pkg::*;

  // eight reflected shift steps, LSB of the byte first
  always_comb begin
    logic [15:0] c;
    c = crc_in;
    for (int b = 0; b < 8; b++) begin
      if (c[0] ^ data[b]) c = (c >> 1) ^ polynomial;
      else                c = c >> 1;
    end
    crc_out = c;
  end

endmodule

### design/crc16_frame_generate_check.sv
`timescale 1ns / 1ps
// CRC-16 (reflected, init all ones) frame generator and checker.
// Throughput: one byte per cycle while the skid stage is empty; the eight CRC bit steps are combinational.
// The result of a final byte is registered in the output register, or in the skid stage while the output stalls.
// An output register with a skid stage lets bytes flow while a result waits.
// Reset: rst_n synchronous, active low; clears frame state, sets 0x8408 / generate.
module crc16_frame_generate_check (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  crcfg_pkg::crcfg_in_t   in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output crcfg_pkg::crcfg_out_t  out_data,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);
  `include "crc16_frame_generate_check_defines.svh"
  import crcfg_pkg::*;

  crcfg_cfg_t  cfg;
  logic        in_fire;
  logic [15:0] crc_r, crc_nxt, crc_step;
  logic [7:0]  hold0_r, hold0_nxt, hold1_r, hold1_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [7:0]  step_byte;
  logic        step_en;
  logic [15:0] fin;
  logic        res_v;
  crcfg_out_t  res;
  logic        out_v_r, skid_v_r;
  crcfg_out_t  out_d_r, skid_d_r;

  crcfg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign in_ready = !skid_v_r;
  assign in_fire  = in_valid && in_ready;

  // check mode folds the oldest held byte once the delay line is full
  assign step_byte = cfg.check_mode ? hold0_r : in_data.data_byte;
  assign step_en   = !cfg.check_mode || (cnt_r == 2'd2);

  crcfg_crc_byte u_crc (
    .crc_in     (crc_r),
    .data       (step_byte),
    .polynomial (cfg.polynomial),
    .crc_out    (crc_step)
  );

  always_comb begin
    crc_nxt   = step_en ? crc_step : crc_r;
    hold0_nxt = hold0_r;
    hold1_nxt = hold1_r;
    if (!cfg.check_mode) begin
      cnt_nxt = 2'd0;
    end else if (cnt_r == 2'd2) begin
      hold0_nxt = hold1_r;
      hold1_nxt = in_data.data_byte;
      cnt_nxt   = 2'd2;
    end else begin
      if (cnt_r[0]) hold1_nxt = in_data.data_byte;
      else          hold0_nxt = in_data.data_byte;
      cnt_nxt = cnt_r + 2'd1;
    end

    fin = ~crc_nxt;
    fin = {fin[7:0], fin[15:8]};
    res = '0;
    if (!cfg.check_mode) begin
      res.crc_value = fin;
    end else if (cnt_nxt != 2'd2) begin
      res.frame_too_short = 1'b1;
    end else begin
      res.crc_value = fin;
      res.crc_match = (fin[7:0] == hold0_nxt) && (fin[15:8] == hold1_nxt);
    end
  end

  assign res_v = in_fire && in_data.last_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r   <= CRC_INIT;
      hold0_r <= 8'd0;
      hold1_r <= 8'd0;
      cnt_r   <= 2'd0;
    end else if (in_fire) begin
      if (in_data.last_byte) begin
        crc_r   <= CRC_INIT;
        hold0_r <= 8'd0;
        hold1_r <= 8'd0;
        cnt_r   <= 2'd0;
      end else begin
        crc_r   <= crc_nxt;
        hold0_r <= hold0_nxt;
        hold1_r <= hold1_nxt;
        cnt_r   <= cnt_nxt;
      end
    end
  end

  // output register plus skid; skid only fills while the output is stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_v_r && !out_ready) begin
      if (res_v) begin
        skid_v_r <= 1'b1;
        skid_d_r <= res;
      end
    end else if (skid_v_r) begin
      out_v_r  <= 1'b1;
      out_d_r  <= skid_d_r;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r <= res_v;
      if (res_v) out_d_r <= res;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_d_r;

  `CRCFG_ASSERT_NOW(a_skid_behind_out, clk, rst_n, skid_v_r, out_v_r)
  `CRCFG_ASSERT_NEXT(a_frame_cleared, clk, rst_n, res_v, (crc_r == CRC_INIT) && (cnt_r == 2'd0))
  `CRCFG_ASSERT_NEXT(a_stall_to_skid, clk, rst_n, out_v_r && !out_ready && res_v, skid_v_r)
  `CRCFG_ASSERT_NOW(a_short_no_match, clk, rst_n, out_v_r && out_d_r.frame_too_short, (out_d_r.crc_value == 16'd0) && !out_d_r.crc_match)

endmodule

### bench/crc16_frame_monitor.sv
`timescale 1ns / 1ps
module crc16_frame_monitor (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  crcfg_pkg::crcfg_in_t  in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  crcfg_pkg::crcfg_out_t out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  input  logic                  pready,
  output int                    mismatches,
  output int                    outstanding
);
  import crcfg_pkg::*;

  logic [15:0] poly_copy;
  logic        check_on;
  logic [15:0] running_fcs;
  logic [7:0]  held [2];
  logic [1:0]  held_count;
  crcfg_out_t  fcs_expected [$];
  int          fail_count = 0;
  int          queued = 0;

  assign mismatches  = fail_count;
  assign outstanding = queued;

  function automatic logic [15:0] crc_update(logic [15:0] crc, logic [7:0] d,
                                             logic [15:0] poly);
    for (int i = 0; i < 8; i++) begin
      if (crc[0] ^ d[i]) crc = (crc >> 1) ^ poly;
      else crc = crc >> 1;
    end
    return crc;
  endfunction

  function automatic logic [15:0] fcs_swap(logic [15:0] crc);
    logic [15:0] inv;
    inv = ~crc;
    return {inv[7:0], inv[15:8]};
  endfunction

  task automatic clear_frame();
    running_fcs = CRC_INIT;
    held[0]     = 8'h00;
    held[1]     = 8'h00;
    held_count  = 2'd0;
  endtask

  task automatic fold_frame_byte(input crcfg_in_t item);
    crcfg_out_t res;
    res = '0;
    if (!check_on) begin
      held_count  = 2'd0;
      running_fcs = crc_update(running_fcs, item.data_byte, poly_copy);
      if (item.last_byte) begin
        res.crc_value = fcs_swap(running_fcs);
        fcs_expected.push_back(res);
        clear_frame();
      end
    end else begin
      // two-byte delay line; oldest byte goes into the CRC once full
      if (held_count >= 2'd2) begin
        running_fcs = crc_update(running_fcs, held[0], poly_copy);
        held[0] = held[1];
        held[1] = item.data_byte;
      end else begin
        held[held_count[0]] = item.data_byte;
        held_count = held_count + 2'd1;
      end
      if (item.last_byte) begin
        if (held_count < 2'd2) begin
          res.frame_too_short = 1'b1;
        end else begin
          res.crc_value = fcs_swap(running_fcs);
          res.crc_match = (res.crc_value[7:0] == held[0]) &&
                          (res.crc_value[15:8] == held[1]);
        end
        fcs_expected.push_back(res);
        clear_frame();
      end
    end
  endtask

  always @(posedge clk) begin
    crcfg_out_t want;
    if (!rst_n) begin
      poly_copy = POLY_RESET;
      check_on  = 1'b0;
      clear_frame();
      fcs_expected.delete();
    end else begin
      // compare before predicting so a result can never meet its own byte
      if (out_valid && out_ready) begin
        if (fcs_expected.size() == 0) begin
          $error("unexpected transaction: %h", out_data);
          fail_count++;
        end else begin
          want = fcs_expected.pop_front();
          if (out_data.crc_value !== want.crc_value) begin
            $error("crc_value: expected %h, actual %h", want.crc_value, out_data.crc_value);
            fail_count++;
          end
          if (out_data.crc_match !== want.crc_match) begin
            $error("crc_match: expected %b, actual %b", want.crc_match, out_data.crc_match);
            fail_count++;
          end
          if (out_data.frame_too_short !== want.frame_too_short) begin
            $error("frame_too_short: expected %b, actual %b",
                   want.frame_too_short, out_data.frame_too_short);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) fold_frame_byte(in_data);
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_POLY) poly_copy = pwdata[15:0];
        else check_on = pwdata[0];
      end
    end
    queued = fcs_expected.size();
  end

endmodule

### bench/crc16_frame_generate_check_test.sv
`timescale 1ns / 1ps
module crc16_frame_generate_check_test;
  import crcfg_pkg::*;

  localparam logic MODE_GENERATE = 1'b0;
  localparam logic MODE_CHECK    = 1'b1;
  localparam int   BYTE_TARGET   = 625;
  localparam int   CYCLE_LIMIT   = 200000;
  localparam int   SETTLE_CYCLES = 4;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  crcfg_in_t   in_data;
  logic        out_valid;
  logic        out_ready;
  crcfg_out_t  out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          mismatches;
  int          outstanding;

  int          cycle_count = 0;
  int          bytes_sent = 0;
  bit          no_idle = 1'b0;
  logic [15:0] cur_poly = POLY_RESET;
  logic [7:0]  frame_buf [$];

  crc16_frame_generate_check u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  crc16_frame_monitor u_monitor (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("crc16_frame_generate_check regression: fail");
      $finish;
    end
  end

  // swapped, inverted FCS of frame_buf under the current polynomial
  function automatic logic [15:0] frame_fcs();
    logic [15:0] crc;
    logic [15:0] inv;
    crc = CRC_INIT;
    foreach (frame_buf[k]) begin
      for (int i = 0; i < 8; i++) begin
        if (crc[0] ^ frame_buf[k][i]) crc = (crc >> 1) ^ cur_poly;
        else crc = crc >> 1;
      end
    end
    inv = ~crc;
    return {inv[7:0], inv[15:8]};
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic fin);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid           <= 1'b1;
    in_data.data_byte  <= b;
    in_data.last_byte  <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_frame(input bit closed);
    foreach (frame_buf[i]) push_byte(frame_buf[i], closed && (i == frame_buf.size() - 1));
  endtask

  task automatic append_fcs(input bit corrupt);
    logic [15:0] fcs;
    int          pos;
    fcs = frame_fcs();
    frame_buf.push_back(fcs[7:0]);
    frame_buf.push_back(fcs[15:8]);
    if (corrupt) begin
      pos = $urandom_range(0, frame_buf.size() - 1);
      frame_buf[pos][$urandom_range(0, 7)] ^= 1'b1;
    end
  endtask

  task automatic fill_random(input int n);
    frame_buf.delete();
    repeat (n) frame_buf.push_back(8'($urandom));
  endtask

  // block idle: nothing pending and the pipeline given time to empty
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic reg_write(input logic idx, input logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_POLY) cur_poly = val[15:0];
  endtask

  // result side: random stall before each transaction unless no_idle is set
  initial begin
    int stall;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 4);
      @(negedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    int phase_end;
    int kind;
    logic mode;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // generate mode, reset polynomial
    frame_buf = '{8'h00};
    send_frame(1'b1);
    frame_buf = '{8'hFF};
    send_frame(1'b1);
    frame_buf = '{8'h00, 8'hFF, 8'h55, 8'hAA};
    send_frame(1'b1);

    settle();
    reg_write(REG_POLY, 32'hA5A5_FFFF);
    reg_write(REG_MODE, 32'(MODE_CHECK));
    frame_buf = '{8'hA5};          // too short for a trailer
    send_frame(1'b1);
    frame_buf = '{8'h01, 8'h80, 8'hFE};
    append_fcs(1'b0);
    send_frame(1'b1);
    frame_buf.delete();            // trailer only
    append_fcs(1'b0);
    send_frame(1'b1);
    frame_buf = '{8'h3C};
    append_fcs(1'b0);
    frame_buf[2] ^= 8'h80;
    send_frame(1'b1);

    // mode switch mid-frame, both ways
    frame_buf = '{8'h11, 8'h22, 8'h33};
    send_frame(1'b0);
    settle();
    reg_write(REG_MODE, 32'(MODE_GENERATE));
    frame_buf = '{8'h44, 8'h55};
    send_frame(1'b1);
    frame_buf = '{8'h66, 8'h77};
    send_frame(1'b0);
    settle();
    reg_write(REG_MODE, 32'(MODE_CHECK));
    frame_buf = '{8'h88, 8'h99, 8'hAA};
    send_frame(1'b1);

    // polynomial switch mid-frame
    frame_buf = '{8'hC3};
    send_frame(1'b0);
    settle();
    reg_write(REG_POLY, 32'h0000_0000);
    frame_buf = '{8'h5A, 8'h00};
    send_frame(1'b1);

    while (bytes_sent < BYTE_TARGET) begin
      settle();
      case ($urandom_range(0, 4))
        0: reg_write(REG_POLY, {16'($urandom), POLY_RESET});
        1: reg_write(REG_POLY, 32'h0000_0000);
        2: reg_write(REG_POLY, 32'hFFFF_FFFF);
        default: reg_write(REG_POLY, $urandom);
      endcase
      mode = ($urandom_range(0, 2) != 0) ? MODE_CHECK : MODE_GENERATE;
      reg_write(REG_MODE, {31'($urandom), mode});
      no_idle   = ($urandom_range(0, 3) == 0);
      phase_end = bytes_sent + $urandom_range(20, 60);
      while (bytes_sent < phase_end) begin
        kind = $urandom_range(0, 9);
        if (mode == MODE_GENERATE) begin
          fill_random((kind == 0) ? 1 : $urandom_range(1, 8));
        end else if (kind <= 6) begin
          fill_random($urandom_range(0, 6));
          append_fcs(1'b0);
        end else if (kind == 7) begin
          fill_random($urandom_range(0, 6));
          append_fcs(1'b1);
        end else if (kind == 8) begin
          fill_random(1);
        end else begin
          fill_random($urandom_range(1, 6));
        end
        send_frame(1'b1);
      end
      // sometimes leave a frame open across the register change
      if ($urandom_range(0, 3) == 0) begin
        fill_random($urandom_range(1, 3));
        send_frame(1'b0);
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) $display("crc16_frame_generate_check regression: pass");
    else $display("crc16_frame_generate_check regression: fail");
    $finish;
  end

endmodule
